[rtl/hsv_color_blob_bounding_box_unit_assert.svh]
// Assertion macros used by the port checker of the HSV blob box unit.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef HSV_COLOR_BLOB_BOUNDING_BOX_UNIT_ASSERT_SVH
`define HSV_COLOR_BLOB_BOUNDING_BOX_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define HSVBB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsvbb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define HSVBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsvbb: next-cycle check failed");

`endif

[rtl/hsvbb_pkg.sv]
// Types, constants and register map of the HSV blob bounding box unit.
// Used by the top level, front end, queue and back end; depends on nothing.
package hsvbb_pkg;

    // field widths
    localparam int CHAN_W  = 8;
    localparam int COORD_W = 11;
    localparam int CDBL_W  = COORD_W + 1;
    localparam int COUNT_W = 23;

    // largest legal coordinate plus one
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COORD_W-1:0] EDGE_ONES = {COORD_W{1'b1}};

    // classification queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    // register map: index = paddr[4:2]
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam logic [2:0] REG_HUE_CENTRE      = 3'd0;
    localparam logic [2:0] REG_HUE_HALF_WINDOW = 3'd1;
    localparam logic [2:0] REG_SATURATION_MIN  = 3'd2;
    localparam logic [2:0] REG_VALUE_MIN       = 3'd3;
    localparam logic [2:0] REG_MIN_PIXEL_COUNT = 3'd4;

    // register reset values
    localparam logic [7:0]         RST_HUE_CENTRE      = 8'd60;
    localparam logic [6:0]         RST_HUE_HALF_WINDOW = 7'd10;
    localparam logic [6:0]         RST_SATURATION_MIN  = 7'd75;
    localparam logic [6:0]         RST_VALUE_MIN       = 7'd20;
    localparam logic [COUNT_W-1:0] RST_MIN_PIXEL_COUNT = 23'd100;

    typedef struct packed {
        logic [7:0]         hue_centre;
        logic [6:0]         hue_half_window;
        logic [6:0]         saturation_min;
        logic [6:0]         value_min;
        logic [COUNT_W-1:0] min_pixel_count;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               frame_end;
    } t_pixel;

    // one classified pixel, front to back
    typedef struct packed {
        logic               match;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               frame_end;
    } t_class;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               empty;
    } t_q_status;

    typedef struct packed {
        logic               found;
        logic [CDBL_W-1:0]  centre_x_doubled;
        logic [CDBL_W-1:0]  centre_y_doubled;
        logic [COORD_W-1:0] box_width;
        logic [COORD_W-1:0] box_height;
        logic [COUNT_W-1:0] match_count;
    } t_result;

endpackage

[rtl/hsv_color_blob_bounding_box_unit.sv]
// HSV color blob bounding box unit: top level with the register block.
// Depends on hsvbb_pkg, hsvbb_front, hsvbb_queue and hsvbb_back.
//
// Pixel stream in on s_axis: one beat per pixel (BGR, x, y), tlast on the
// frame's last pixel. One result beat per frame on m_axis: found flag,
// doubled box centers, box width and height, and match count.
// Registers sit on the APB port at byte addresses 0x00..0x10; write them
// only while no pixel is in flight.
// Throughput: one pixel per cycle while the queue has room. The front end
// takes a beat only when a slot in the four-entry classification queue is
// reserved for it, which covers the two pipeline stages in flight.
// The last pixel of a frame passes both front stages and the queue, then
// the result is registered once the output register is free.
// When the receiver stalls, the result holds; pixels keep flowing until a
// second frame end reaches the accumulator, then the queue fills and
// s_axis_tready drops.
// Reset (synchronous, active low) restores register defaults, clears the
// count, sets the edges to their empty values and empties the queue.
module hsv_color_blob_bounding_box_unit #(
    parameter int MAX_WIDTH  = hsvbb_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = hsvbb_pkg::MAX_HEIGHT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // pixel stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [7:0] blue, [15:8] green, [23:16] red, [34:24] pixel_x, [45:35] pixel_y
    input  logic [47:0]                  s_axis_tdata,
    input  logic                         s_axis_tlast,
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [0] found, [12:1] centre_x_doubled, [24:13] centre_y_doubled,
    // [35:25] box_width, [46:36] box_height, [69:47] match_count
    output logic [71:0]                  m_axis_tdata,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hsvbb_pkg::APB_AW-1:0] paddr,
    input  logic [hsvbb_pkg::APB_DW-1:0] pwdata,
    output logic [hsvbb_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import hsvbb_pkg::*;

    t_cfg      r_cfg;
    t_pixel    w_pixel;
    t_class    w_push_entry;
    t_class    w_head;
    t_q_status w_q_status;
    t_result   w_result;
    logic      w_push;
    logic      w_pop;
    logic      w_wr;
    logic [2:0] w_reg_idx;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_centre      <= RST_HUE_CENTRE;
            r_cfg.hue_half_window <= RST_HUE_HALF_WINDOW;
            r_cfg.saturation_min  <= RST_SATURATION_MIN;
            r_cfg.value_min       <= RST_VALUE_MIN;
            r_cfg.min_pixel_count <= RST_MIN_PIXEL_COUNT;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_HUE_CENTRE:      r_cfg.hue_centre      <= pwdata[7:0];
                REG_HUE_HALF_WINDOW: r_cfg.hue_half_window <= pwdata[6:0];
                REG_SATURATION_MIN:  r_cfg.saturation_min  <= pwdata[6:0];
                REG_VALUE_MIN:       r_cfg.value_min       <= pwdata[6:0];
                REG_MIN_PIXEL_COUNT: r_cfg.min_pixel_count <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_reg_idx)
            REG_HUE_CENTRE:      prdata = APB_DW'(r_cfg.hue_centre);
            REG_HUE_HALF_WINDOW: prdata = APB_DW'(r_cfg.hue_half_window);
            REG_SATURATION_MIN:  prdata = APB_DW'(r_cfg.saturation_min);
            REG_VALUE_MIN:       prdata = APB_DW'(r_cfg.value_min);
            REG_MIN_PIXEL_COUNT: prdata = APB_DW'(r_cfg.min_pixel_count);
            default:             prdata = '0;
        endcase
    end

    // unpack pixel beat
    assign w_pixel.blue      = s_axis_tdata[7:0];
    assign w_pixel.green     = s_axis_tdata[15:8];
    assign w_pixel.red       = s_axis_tdata[23:16];
    assign w_pixel.pixel_x   = s_axis_tdata[34:24];
    assign w_pixel.pixel_y   = s_axis_tdata[45:35];
    assign w_pixel.frame_end = s_axis_tlast;

    hsvbb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (s_axis_tvalid),
        .i_pixel    (w_pixel),
        .o_ready    (s_axis_tready),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    hsvbb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    hsvbb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_result)
    );

    // pack result beat
    assign m_axis_tdata = {2'b00,
                           w_result.match_count,
                           w_result.box_height,
                           w_result.box_width,
                           w_result.centre_y_doubled,
                           w_result.centre_x_doubled,
                           w_result.found};

endmodule

[rtl/hsvbb_front.sv]
// Front end: HSV conversion and threshold test, three stages, credit flow control.
// Depends on hsvbb_pkg; pushes classified pixels into hsvbb_queue.
module hsvbb_front #(
    parameter int MAX_WIDTH  = hsvbb_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = hsvbb_pkg::MAX_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hsvbb_pkg::t_cfg     i_cfg,
    input  logic                i_valid,
    input  hsvbb_pkg::t_pixel   i_pixel,
    output logic                o_ready,
    input  hsvbb_pkg::t_q_status i_q_status,
    output logic                o_push,
    output hsvbb_pkg::t_class   o_entry
);
    import hsvbb_pkg::*;

    typedef enum logic [1:0] {HUE_NONE, HUE_RED, HUE_GREEN, HUE_BLUE} t_hue_sel;

    logic               w_accept;
    logic [CHAN_W-1:0]  w_mx;
    logic [CHAN_W-1:0]  w_mn;
    t_hue_sel           w_sel;
    logic [7:0]         w_base;
    logic signed [8:0]  w_diff;
    logic               w_coord_ok;

    // stage 1: max, min, hue sector
    logic               r1_valid;
    logic [7:0]         r1_base;
    logic signed [8:0]  r1_diff;
    logic [CHAN_W-1:0]  r1_d;
    logic [CHAN_W-1:0]  r1_mx;
    logic [COORD_W-1:0] r1_x;
    logic [COORD_W-1:0] r1_y;
    logic               r1_last;
    logic               r1_coord_ok;

    // stage 2: scaled hue, bounds and products
    logic [15:0]        w_base_prod;
    logic signed [17:0] w_diff30;
    logic signed [9:0]  w_lo_c;
    logic [9:0]         w_hi_c;
    logic               r2_valid;
    logic signed [17:0] r2_hnum;
    logic signed [18:0] r2_lo;
    logic [18:0]        r2_hi;
    logic [14:0]        r2_sat_l;
    logic [14:0]        r2_sat_r;
    logic               r2_mx_zero;
    logic [14:0]        r2_val_l;
    logic [14:0]        r2_val_r;
    logic [COORD_W-1:0] r2_x;
    logic [COORD_W-1:0] r2_y;
    logic               r2_last;
    logic               r2_coord_ok;

    logic               w_hue_ok;
    logic               w_sat_ok;
    logic               w_val_ok;

    // accept only with a queue slot reserved for every pixel in flight
    assign o_ready  = (LEVEL_W'(i_q_status.level) + LEVEL_W'(r1_valid) + LEVEL_W'(r2_valid))
                      < LEVEL_W'(QUEUE_DEPTH);
    assign w_accept = i_valid && o_ready;

    // channel extremes
    always_comb begin
        w_mx = i_pixel.red;
        if (i_pixel.green > w_mx) w_mx = i_pixel.green;
        if (i_pixel.blue > w_mx)  w_mx = i_pixel.blue;
        w_mn = i_pixel.red;
        if (i_pixel.green < w_mn) w_mn = i_pixel.green;
        if (i_pixel.blue < w_mn)  w_mn = i_pixel.blue;
    end

    // hue sector; red wins ties, then green
    always_comb begin
        priority if (w_mx == w_mn)        w_sel = HUE_NONE;
        else if (w_mx == i_pixel.red)     w_sel = HUE_RED;
        else if (w_mx == i_pixel.green)   w_sel = HUE_GREEN;
        else                              w_sel = HUE_BLUE;
    end

    always_comb begin
        unique case (w_sel)
            HUE_RED: begin
                w_base = (i_pixel.green < i_pixel.blue) ? 8'd180 : 8'd0;
                w_diff = $signed({1'b0, i_pixel.green}) - $signed({1'b0, i_pixel.blue});
            end
            HUE_GREEN: begin
                w_base = 8'd60;
                w_diff = $signed({1'b0, i_pixel.blue}) - $signed({1'b0, i_pixel.red});
            end
            HUE_BLUE: begin
                w_base = 8'd120;
                w_diff = $signed({1'b0, i_pixel.red}) - $signed({1'b0, i_pixel.green});
            end
            default: begin
                w_base = 8'd0;
                w_diff = 9'sd0;
            end
        endcase
    end

    assign w_coord_ok = (32'(i_pixel.pixel_x) < 32'(MAX_WIDTH))
                     && (32'(i_pixel.pixel_y) < 32'(MAX_HEIGHT));

    // stage 2 arithmetic: hue times d and window bounds times d
    assign w_base_prod = {8'b0, r1_base} * {8'b0, r1_d};
    assign w_diff30    = 18'(r1_diff) * 18'sd30;
    assign w_lo_c      = $signed({2'b0, i_cfg.hue_centre}) - $signed({3'b0, i_cfg.hue_half_window});
    assign w_hi_c      = {2'b0, i_cfg.hue_centre} + {3'b0, i_cfg.hue_half_window};

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            r1_valid <= w_accept;
            r2_valid <= r1_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r1_base     <= w_base;
        r1_diff     <= w_diff;
        r1_d        <= w_mx - w_mn;
        r1_mx       <= w_mx;
        r1_x        <= i_pixel.pixel_x;
        r1_y        <= i_pixel.pixel_y;
        r1_last     <= i_pixel.frame_end;
        r1_coord_ok <= w_coord_ok;

        r2_hnum     <= $signed({2'b00, w_base_prod}) + w_diff30;
        r2_lo       <= 19'(w_lo_c) * $signed({11'b0, r1_d});
        r2_hi       <= {9'b0, w_hi_c} * {11'b0, r1_d};
        r2_sat_l    <= {7'b0, r1_d} * 15'd100;
        r2_sat_r    <= {8'b0, i_cfg.saturation_min} * {7'b0, r1_mx};
        r2_mx_zero  <= (r1_mx == '0);
        r2_val_l    <= {7'b0, r1_mx} * 15'd100;
        r2_val_r    <= {8'b0, i_cfg.value_min} * 15'd255;
        r2_x        <= r1_x;
        r2_y        <= r1_y;
        r2_last     <= r1_last;
        r2_coord_ok <= r1_coord_ok;
    end

    // stage 3: compares, straight into the queue
    assign w_hue_ok = !(19'(r2_hnum) < r2_lo) && !(19'(r2_hnum) > $signed(r2_hi));
    assign w_sat_ok = r2_mx_zero ? (i_cfg.saturation_min == '0) : !(r2_sat_l < r2_sat_r);
    assign w_val_ok = !(r2_val_l < r2_val_r);

    assign o_push            = r2_valid;
    assign o_entry.match     = r2_coord_ok && w_hue_ok && w_sat_ok && w_val_ok;
    assign o_entry.pixel_x   = r2_x;
    assign o_entry.pixel_y   = r2_y;
    assign o_entry.frame_end = r2_last;

endmodule

[rtl/hsvbb_queue.sv]
// Short FIFO of classified pixels between front end and accumulator.
// Depends on hsvbb_pkg; never written when full thanks to the front's credit check.
module hsvbb_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hsvbb_pkg::t_class    i_entry,
    input  logic                 i_pop,
    output hsvbb_pkg::t_class    o_head,
    output hsvbb_pkg::t_q_status o_status
);
    import hsvbb_pkg::*;

    t_class             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [LEVEL_W-1:0] r_level;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            if (i_pop)  r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            if (i_push && !i_pop)      r_level <= LEVEL_W'(r_level + 1'b1);
            else if (!i_push && i_pop) r_level <= LEVEL_W'(r_level - 1'b1);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_entry;
    end

    assign o_head         = r_slot[r_rd_ptr];
    assign o_status.level = r_level;
    assign o_status.empty = (r_level == '0);

endmodule

[rtl/hsvbb_back.sv]
// Back end: match count, bounding box edges and the registered frame result.
// Depends on hsvbb_pkg; drains hsvbb_queue and drives the result stream.
module hsvbb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hsvbb_pkg::t_cfg      i_cfg,
    input  hsvbb_pkg::t_class    i_head,
    input  hsvbb_pkg::t_q_status i_q_status,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hsvbb_pkg::t_result   o_result
);
    import hsvbb_pkg::*;

    logic [COUNT_W-1:0] r_total;
    logic [COORD_W-1:0] r_left;
    logic [COORD_W-1:0] r_top;
    logic [COORD_W-1:0] r_right;
    logic [COORD_W-1:0] r_bottom;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_hit;
    logic               w_close;
    logic [COUNT_W-1:0] n_total;
    logic [COORD_W-1:0] n_left;
    logic [COORD_W-1:0] n_top;
    logic [COORD_W-1:0] n_right;
    logic [COORD_W-1:0] n_bottom;
    logic               n_found;
    logic               n_geom;
    t_result            n_out;

    // a frame-end beat waits only for the output register
    assign o_pop   = !i_q_status.empty && (!i_head.frame_end || !r_out_valid || i_ready);
    assign w_hit   = o_pop && i_head.match;
    assign w_close = o_pop && i_head.frame_end;

    // accumulator update, count saturates
    always_comb begin
        n_total  = r_total;
        n_left   = r_left;
        n_top    = r_top;
        n_right  = r_right;
        n_bottom = r_bottom;
        if (w_hit) begin
            if (r_total != COUNT_MAX)    n_total  = COUNT_W'(r_total + 1'b1);
            if (i_head.pixel_x < r_left)   n_left   = i_head.pixel_x;
            if (i_head.pixel_y < r_top)    n_top    = i_head.pixel_y;
            if (i_head.pixel_x > r_right)  n_right  = i_head.pixel_x;
            if (i_head.pixel_y > r_bottom) n_bottom = i_head.pixel_y;
        end
    end

    // frame result; geometry zero unless found with at least one match
    always_comb begin
        n_found                = (n_total >= i_cfg.min_pixel_count);
        n_geom                 = n_found && (n_total != '0);
        n_out.found            = n_found;
        n_out.match_count      = n_total;
        n_out.centre_x_doubled = n_geom ? CDBL_W'(n_left) + CDBL_W'(n_right) : '0;
        n_out.centre_y_doubled = n_geom ? CDBL_W'(n_top) + CDBL_W'(n_bottom) : '0;
        n_out.box_width        = n_geom ? COORD_W'(n_right - n_left) : '0;
        n_out.box_height       = n_geom ? COORD_W'(n_bottom - n_top) : '0;
    end

    // accumulators and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_left      <= EDGE_ONES;
            r_top       <= EDGE_ONES;
            r_right     <= '0;
            r_bottom    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_close) begin
                r_total  <= '0;
                r_left   <= EDGE_ONES;
                r_top    <= EDGE_ONES;
                r_right  <= '0;
                r_bottom <= '0;
            end else begin
                r_total  <= n_total;
                r_left   <= n_left;
                r_top    <= n_top;
                r_right  <= n_right;
                r_bottom <= n_bottom;
            end
            if (w_close)      r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_close) r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[rtl/hsvbb_checker.sv]
// Port-level checks on the result stream of the HSV blob bounding box unit.
// Depends on hsv_color_blob_bounding_box_unit_assert.svh; bound to the top level.
`include "hsv_color_blob_bounding_box_unit_assert.svh"

module hsvbb_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] i_m_tdata
);

    // stalled result beat stays up
    `HSVBB_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)

    // stalled result beat keeps its payload
    `HSVBB_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, $stable(i_m_tdata))

    // nothing found: geometry reads zero
    `HSVBB_ASSERT_IMPL(a_empty_geom, i_clk, i_rst_n, i_m_tvalid && !i_m_tdata[0], i_m_tdata[46:1] == 46'd0)

    // sum and difference of the same edges share parity
    `HSVBB_ASSERT_IMPL(a_box_parity, i_clk, i_rst_n, i_m_tvalid, (i_m_tdata[1] == i_m_tdata[25]) && (i_m_tdata[13] == i_m_tdata[36]))

endmodule

bind hsv_color_blob_bounding_box_unit hsvbb_port_checker u_hsvbb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

[bench/hsvbb_checker.sv]
// Checker for the HSV color blob bounding box unit: watches the pixel, result
// and register ports, predicts each frame's box and compares it field by field.
// Depends on hsvbb_pkg for field widths, register indexes and result layout.
module hsvbb_checker
    import hsvbb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel stream, as seen at the block's slave side
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    // [7:0] blue, [15:8] green, [23:16] red, [34:24] pixel_x, [45:35] pixel_y
    input  logic [47:0]       s_axis_tdata,
    input  logic              s_axis_tlast,
    // result stream, as seen at the block's master side
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [0] found, [12:1] centre_x_doubled, [24:13] centre_y_doubled,
    // [35:25] box_width, [46:36] box_height, [69:47] match_count
    input  logic [71:0]       m_axis_tdata,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    // status for the bench top
    output int                o_fail_count,
    output int                o_pending,
    output int                o_pixel_beats,
    output int                o_result_beats,
    output int                o_found_frames
);

    // shadow registers and frame accumulators
    t_cfg               shadow_cfg;
    logic [COUNT_W-1:0] hit_count;
    logic [COORD_W-1:0] left_x, top_y, right_x, bottom_y;

    // boxes predicted for frames whose result beat has not come yet
    t_result            pending_boxes[$];

    int                 mismatches;
    int                 pixel_beats;
    int                 result_beats;
    int                 found_frames;

    // exact HSV window test by cross-multiplication
    function automatic bit pixel_in_window(input t_cfg c, input int b, input int g,
                                           input int r);
        int mx, mn, d, hue_num, lo, hi;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;

        // hue scaled by d, half-degree units
        if (d == 0) begin
            hue_num = 0;
        end else if (mx == r) begin
            hue_num = 30 * (g - b);
            if (g < b) hue_num += 180 * d;
        end else if (mx == g) begin
            hue_num = 60 * d + 30 * (b - r);
        end else begin
            hue_num = 120 * d + 30 * (r - g);
        end

        // window bounds are signed and never wrap
        lo = (int'(c.hue_centre) - int'(c.hue_half_window)) * d;
        hi = (int'(c.hue_centre) + int'(c.hue_half_window)) * d;
        if (hue_num < lo || hue_num > hi) return 1'b0;

        if (mx == 0) begin
            if (c.saturation_min != 0) return 1'b0;
        end else if (100 * d < int'(c.saturation_min) * mx) begin
            return 1'b0;
        end

        if (100 * mx < int'(c.value_min) * 255) return 1'b0;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("box field %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result            want;
        t_result            got;
        t_pixel             px;
        logic [CDBL_W-1:0]  lsum, tsum;

        if (!i_rst_n) begin
            shadow_cfg.hue_centre      = RST_HUE_CENTRE;
            shadow_cfg.hue_half_window = RST_HUE_HALF_WINDOW;
            shadow_cfg.saturation_min  = RST_SATURATION_MIN;
            shadow_cfg.value_min       = RST_VALUE_MIN;
            shadow_cfg.min_pixel_count = RST_MIN_PIXEL_COUNT;
            hit_count    = '0;
            left_x       = EDGE_ONES;
            top_y        = EDGE_ONES;
            right_x      = '0;
            bottom_y     = '0;
            pending_boxes.delete();
            mismatches   = 0;
            pixel_beats  = 0;
            result_beats = 0;
            found_frames = 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_HUE_CENTRE:      shadow_cfg.hue_centre      = pwdata[7:0];
                    REG_HUE_HALF_WINDOW: shadow_cfg.hue_half_window = pwdata[6:0];
                    REG_SATURATION_MIN:  shadow_cfg.saturation_min  = pwdata[6:0];
                    REG_VALUE_MIN:       shadow_cfg.value_min       = pwdata[6:0];
                    REG_MIN_PIXEL_COUNT: shadow_cfg.min_pixel_count = pwdata[COUNT_W-1:0];
                    default: ;
                endcase
            end

            // result beat against the oldest predicted box
            if (m_axis_tvalid && m_axis_tready) begin
                result_beats++;
                got.found            = m_axis_tdata[0];
                got.centre_x_doubled = m_axis_tdata[12:1];
                got.centre_y_doubled = m_axis_tdata[24:13];
                got.box_width        = m_axis_tdata[35:25];
                got.box_height       = m_axis_tdata[46:36];
                got.match_count      = m_axis_tdata[69:47];
                if (pending_boxes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat with no frame waiting: tdata %h", m_axis_tdata);
                end else begin
                    want = pending_boxes.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("centre_x_doubled", want.centre_x_doubled,
                                got.centre_x_doubled);
                    check_field("centre_y_doubled", want.centre_y_doubled,
                                got.centre_y_doubled);
                    check_field("box_width", want.box_width, got.box_width);
                    check_field("box_height", want.box_height, got.box_height);
                    check_field("match_count", want.match_count, got.match_count);
                end
            end

            // pixel beat: classify, accumulate, close the frame on tlast
            if (s_axis_tvalid && s_axis_tready) begin
                pixel_beats++;
                px.blue      = s_axis_tdata[7:0];
                px.green     = s_axis_tdata[15:8];
                px.red       = s_axis_tdata[23:16];
                px.pixel_x   = s_axis_tdata[34:24];
                px.pixel_y   = s_axis_tdata[45:35];
                px.frame_end = s_axis_tlast;

                if (int'(px.pixel_x) < MAX_WIDTH && int'(px.pixel_y) < MAX_HEIGHT &&
                    pixel_in_window(shadow_cfg, px.blue, px.green, px.red)) begin
                    if (hit_count != COUNT_MAX) hit_count++;
                    if (px.pixel_x < left_x)   left_x   = px.pixel_x;
                    if (px.pixel_y < top_y)    top_y    = px.pixel_y;
                    if (px.pixel_x > right_x)  right_x  = px.pixel_x;
                    if (px.pixel_y > bottom_y) bottom_y = px.pixel_y;
                end

                if (px.frame_end) begin
                    want = '0;
                    want.found       = (hit_count >= shadow_cfg.min_pixel_count);
                    want.match_count = hit_count;
                    if (want.found && hit_count != 0) begin
                        lsum = {1'b0, left_x} + {1'b0, right_x};
                        tsum = {1'b0, top_y} + {1'b0, bottom_y};
                        want.centre_x_doubled = lsum;
                        want.centre_y_doubled = tsum;
                        want.box_width        = right_x - left_x;
                        want.box_height       = bottom_y - top_y;
                    end
                    if (want.found) found_frames++;
                    pending_boxes.push_back(want);
                    hit_count = '0;
                    left_x    = EDGE_ONES;
                    top_y     = EDGE_ONES;
                    right_x   = '0;
                    bottom_y  = '0;
                end
            end
        end

        o_fail_count   <= mismatches;
        o_pending      <= pending_boxes.size();
        o_pixel_beats  <= pixel_beats;
        o_result_beats <= result_beats;
        o_found_frames <= found_frames;
    end

endmodule

[bench/tb_top.sv]
// Bench top for the HSV color blob bounding box unit: clock, reset, pixel and
// register stimulus, result-side backpressure and the verdict.
// Depends on hsvbb_pkg, the block itself and hsvbb_checker.
module tb_top;
    import hsvbb_pkg::*;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              s_axis_tvalid  = 1'b0;
    logic              s_axis_tready;
    // [7:0] blue, [15:8] green, [23:16] red, [34:24] pixel_x, [45:35] pixel_y
    logic [47:0]       s_axis_tdata   = '0;
    logic              s_axis_tlast   = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready  = 1'b0;
    // [0] found, [12:1] centre_x_doubled, [24:13] centre_y_doubled,
    // [35:25] box_width, [46:36] box_height, [69:47] match_count
    logic [71:0]       m_axis_tdata;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [APB_AW-1:0] paddr          = '0;
    logic [APB_DW-1:0] pwdata         = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count, pending, pixel_beats, result_beats, found_frames;

    // run state; steady and hold_request are shared with the result-side process
    bit steady       = 1'b0;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int random_pixels = 0;
    int reg_writes    = 0;

    hsv_color_blob_bounding_box_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    hsvbb_checker box_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_pixel_beats  (pixel_beats),
        .o_result_beats (result_beats),
        .o_found_frames (found_frames)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #5000000;
        $display("hsv_color_blob_bounding_box_unit: mismatch");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 300;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 31);
            end
        end
    end

    // one pixel beat, with random idle cycles ahead of it
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                              input logic [10:0] x, input logic [10:0] y, input bit last);
        while (!steady && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, y, x, r, g, b};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drop valid, wait out every pending frame and the pipeline behind it
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int hc, input int hw, input int sm, input int vm,
                              input int mc);
        settle();
        write_reg(REG_HUE_CENTRE, hc);
        write_reg(REG_HUE_HALF_WINDOW, hw);
        write_reg(REG_SATURATION_MIN, sm);
        write_reg(REG_VALUE_MIN, vm);
        write_reg(REG_MIN_PIXEL_COUNT, mc);
    endtask

    // one frame of mixed pixels, mostly clustered so the box means something
    task automatic send_frame(input int len, input bit spread);
        int          span, x0, y0;
        logic [7:0]  b, g, r;
        logic [10:0] x, y;
        span = $urandom_range(1, 120);
        x0   = $urandom_range(2047 - span);
        y0   = $urandom_range(2047 - span);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(3))
                0: begin
                    b = 8'($urandom); g = 8'($urandom); r = 8'($urandom);
                end
                1: begin
                    b = 8'($urandom_range(0, 60)); g = 8'($urandom_range(180, 255));
                    r = 8'($urandom_range(0, 60));
                end
                2: begin
                    b = 8'($urandom_range(0, 80)); g = 8'($urandom_range(0, 80));
                    r = 8'($urandom_range(200, 255));
                end
                default: begin
                    b = 8'($urandom_range(160, 255)); g = 8'($urandom_range(0, 90));
                    r = 8'($urandom_range(0, 90));
                end
            endcase
            if (spread) begin
                x = 11'($urandom_range(2047));
                y = 11'($urandom_range(2047));
            end else begin
                x = 11'(x0 + $urandom_range(span));
                y = 11'(y0 + $urandom_range(span));
            end
            send_pixel(b, g, r, x, y, k == len - 1);
            random_pixels++;
        end
    endtask

    initial begin : stimulus
        int phase, phase_pixels, len;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: primaries, black, white, corner coordinates
        send_pixel(8'd0,   8'd0,   8'd0,   11'd0,    11'd0,    1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 11'd2047, 11'd2047, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   11'd0,    11'd2047, 1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 11'd2047, 11'd0,    1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   11'd1024, 11'd1024, 1'b0);
        // red largest with green below blue: hue lands past 150
        send_pixel(8'd100, 8'd0,   8'd255, 11'd5,    11'd6,    1'b0);
        send_pixel(8'd200, 8'd255, 8'd50,  11'd7,    11'd8,    1'b0);
        send_pixel(8'd255, 8'd40,  8'd90,  11'd9,    11'd10,   1'b0);
        // red and green tied for largest: red branch wins
        send_pixel(8'd0,   8'd255, 8'd255, 11'd11,   11'd12,   1'b1);

        // zero minimum count with nothing matching: found, empty box
        set_config(0, 0, 75, 20, 0);
        send_pixel(8'd128, 8'd128, 8'd128, 11'd3, 11'd3, 1'b1);

        // widest in-range settings, black passes with zero saturation floor
        set_config(180, 90, 0, 0, 1);
        send_pixel(8'd0,   8'd0, 8'd0,   11'd0,    11'd0,    1'b0);
        send_pixel(8'd255, 8'd0, 8'd0,   11'd2047, 11'd2047, 1'b0);
        send_pixel(8'd0,   8'd0, 8'd255, 11'd100,  11'd50,   1'b1);

        // window reaching below zero hue, no wrap to the top
        set_config(5, 20, 0, 0, 1);
        send_pixel(8'd0,  8'd0,  8'd255, 11'd300, 11'd400, 1'b0);
        send_pixel(8'd60, 8'd0,  8'd255, 11'd310, 11'd390, 1'b0);
        send_pixel(8'd0,  8'd20, 8'd255, 11'd320, 11'd410, 1'b1);

        // register values beyond their nominal range
        set_config(255, 127, 127, 127, 23'h400000);
        send_pixel(8'd255, 8'd255, 8'd255, 11'd1, 11'd1, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   11'd2, 11'd2, 1'b1);

        // full saturation and value floors, largest minimum count
        set_config(60, 90, 100, 100, 23'h7FFFFF);
        send_pixel(8'd0, 8'd255, 8'd0, 11'd2047, 11'd0,    1'b0);
        send_pixel(8'd0, 8'd254, 8'd0, 11'd0,    11'd2047, 1'b1);

        // random frames under a rotating set of thresholds
        for (phase = 0; random_pixels < 850; phase++) begin
            case (phase % 6)
                0: set_config(60, 10, 75, 20, $urandom_range(0, 8));
                1, 2: set_config($urandom_range(0, 180), $urandom_range(0, 90),
                                 $urandom_range(0, 100), $urandom_range(0, 100),
                                 $urandom_range(0, 15));
                3: set_config($urandom_range(0, 10), $urandom_range(20, 90),
                              $urandom_range(0, 60), $urandom_range(0, 60),
                              $urandom_range(0, 5));
                4: set_config($urandom_range(170, 180), $urandom_range(20, 90),
                              $urandom_range(0, 60), $urandom_range(0, 60),
                              $urandom_range(0, 5));
                default: set_config($urandom_range(0, 180), 90, 0, 0, 0);
            endcase
            steady = (phase == 1);
            // receiver goes quiet while short frames keep coming
            if (phase == 2) hold_request = 1'b1;
            phase_pixels = 0;
            while (phase_pixels < 140 && random_pixels < 850) begin
                if (phase == 2)
                    len = $urandom_range(1, 4);
                else if ($urandom_range(9) == 0)
                    len = $urandom_range(40, 80);
                else
                    len = $urandom_range(1, 25);
                send_frame(len, $urandom_range(7) == 0);
                phase_pixels += len;
            end
        end

        steady = 1'b0;
        settle();
        repeat (20) @(posedge i_clk);

        $display("covered %0d pixel beats and %0d register writes", pixel_beats, reg_writes);
        $display("checked %0d frame results, %0d of them with an object found",
                 result_beats, found_frames);
        if (fail_count == 0 && pending == 0) begin
            $display("hsv_color_blob_bounding_box_unit: match");
        end else begin
            $display("hsv_color_blob_bounding_box_unit: mismatch");
        end
        $finish;
    end

endmodule
